// ----- hw/rtl/poh_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// poh_pkg
// Shared types, constants and functions of the orientation histogram block.
// ============================================================================
package poh_pkg;

    localparam int COORD_W   = 24;   // input coordinate width
    localparam int DIFF_W    = 25;   // head minus tail
    localparam int FOLD_W    = 26;   // after minimum-image fold
    localparam int BOX_W     = 23;
    localparam int NBREG_W   = 7;
    localparam int CORDIC_W  = 28;   // holds the CORDIC gain on a folded vector
    localparam int TURN_W    = 32;   // angle accumulator, 2^-32 turn units
    localparam int STEP_W    = 5;    // indexes the 24-entry arctangent table
    localparam int COUNT_W   = 16;
    localparam int BIN_NUM_W = 6;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TURN_W-1:0]  HALF_TURN = 32'h8000_0000;

    // register indexes on the config port
    localparam logic [1:0] REG_NUM_BINS   = 2'd0;
    localparam logic [1:0] REG_BOX_WIDTH  = 2'd1;
    localparam logic [1:0] REG_BOX_HEIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_START,
        ST_ANGLE,
        ST_SCALE,
        ST_ISSUE,
        ST_COUNT
    } poh_state_t;

    typedef enum logic [2:0] {
        BN_IDLE,
        BN_RD,
        BN_WR,
        BN_DRD,
        BN_DOUT
    } poh_bin_state_t;

    typedef struct packed {
        logic update;   // count one filament
        logic dump;     // then emit all bins in use and clear
    } poh_bin_cmd_t;

    // atan(2^-i) in 2^-32 turn units, truncated
    function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [TURN_W-1:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051D;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2E;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    // minimum-image fold, applied once
    function automatic logic signed [FOLD_W-1:0] fold(
        input logic signed [DIFF_W-1:0] d,
        input logic [BOX_W-1:0]         box
    );
        logic signed [FOLD_W:0]   d2;
        logic signed [FOLD_W:0]   bx;
        logic signed [FOLD_W-1:0] de;
        logic signed [FOLD_W-1:0] be;
        logic signed [FOLD_W-1:0] r;
        d2 = {d[DIFF_W-1], d, 1'b0};
        bx = {4'b0000, box};
        de = {d[DIFF_W-1], d};
        be = {3'b000, box};
        if (d2 > bx)
            r = de - be;
        else if (d2 < -bx)
            r = de + be;
        else
            r = de;
        return r;
    endfunction

endpackage

// ----- hw/rtl/periodic_orientation_histogram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// periodic_orientation_histogram
// Filament orientation histogram: minimum-image difference, CORDIC atan2,
// saturating bin count, per-frame dump of all bins in use.
//
//   channel  signals                                          direction
//   config   psel penable pwrite paddr pwdata prdata pready   in / out
//   filament start busy head_x head_y tail_x tail_y frame_end in (busy out)
//   bins     bin_valid bin_number bin_count last_bin          out
//
// From start to busy low a filament passes through fold, one CORDIC
// micro-rotation per cycle, bin scale, counter read and write.
// With frame_end the dump then walks the bins in use, each through a memory
// read and then the output register, with one bin_valid strobe per bin.
// The single-ported counter memory and the shared CORDIC unit set the rate.
// Reset clears all counters at once through per-bin valid bits.
// The bin receiver cannot stall: each strobe is a completed transaction.
// ============================================================================
module periodic_orientation_histogram #(
    parameter int MAX_BINS     = 64,
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [poh_pkg::ADDR_W-1:0]              paddr,
    input  logic [poh_pkg::DATA_W-1:0]              pwdata,
    output logic [poh_pkg::DATA_W-1:0]              prdata,
    output logic                                    pready,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [poh_pkg::COORD_W-1:0]      head_x,
    input  logic signed [poh_pkg::COORD_W-1:0]      head_y,
    input  logic signed [poh_pkg::COORD_W-1:0]      tail_x,
    input  logic signed [poh_pkg::COORD_W-1:0]      tail_y,
    input  logic                                    frame_end,
    output logic                                    bin_valid,
    output logic [poh_pkg::BIN_NUM_W-1:0]           bin_number,
    output logic [poh_pkg::COUNT_W-1:0]             bin_count,
    output logic                                    last_bin
);

    localparam int BIN_W  = $clog2(MAX_BINS);
    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int PROD_W = ANGLE_BITS + NB_W;
    localparam int TW     = poh_pkg::TURN_W;

    // configuration
    logic [poh_pkg::NBREG_W-1:0]    num_bins_reg;
    logic [poh_pkg::BOX_W-1:0]      box_width_reg, box_height_reg;
    logic [1:0]                     reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg   <= 7'd45;
            box_width_reg  <= 23'd25600;
            box_height_reg <= 23'd25600;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                poh_pkg::REG_NUM_BINS:   num_bins_reg   <= pwdata[poh_pkg::NBREG_W-1:0];
                poh_pkg::REG_BOX_WIDTH:  box_width_reg  <= pwdata[poh_pkg::BOX_W-1:0];
                poh_pkg::REG_BOX_HEIGHT: box_height_reg <= pwdata[poh_pkg::BOX_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            poh_pkg::REG_NUM_BINS:   prdata = {25'd0, num_bins_reg};
            poh_pkg::REG_BOX_WIDTH:  prdata = {9'd0, box_width_reg};
            poh_pkg::REG_BOX_HEIGHT: prdata = {9'd0, box_height_reg};
            default:                 prdata = '0;
        endcase
    end

    // bins in use, clamped to 1..MAX_BINS
    logic [NB_W-1:0] nb;

    always_comb
    begin
        if (num_bins_reg == '0)
            nb = NB_W'(1);
        else if (num_bins_reg > poh_pkg::NBREG_W'(MAX_BINS))
            nb = NB_W'(MAX_BINS);
        else
            nb = NB_W'(num_bins_reg);
    end

    // sequencer
    poh_pkg::poh_state_t                state_reg, state_next;
    poh_pkg::poh_bin_cmd_t              bin_cmd;
    logic                               accept, cordic_start, cordic_done, bins_done;
    logic [TW-1:0]                      cordic_angle, turn;
    logic [ANGLE_BITS-1:0]              ang;
    logic [PROD_W-1:0]                  prod_reg;
    logic signed [poh_pkg::DIFF_W-1:0]  dx_reg, dy_reg;
    logic signed [poh_pkg::FOLD_W-1:0]  fx_reg, fy_reg;
    logic                               frame_end_reg;

    assign accept = start && !busy;
    assign busy   = (state_reg != poh_pkg::ST_IDLE);
    assign turn   = cordic_angle + poh_pkg::HALF_TURN;
    assign ang    = turn[TW-1 -: ANGLE_BITS];

    always_comb
    begin
        state_next     = state_reg;
        cordic_start   = 1'b0;
        bin_cmd.update = 1'b0;
        bin_cmd.dump   = frame_end_reg;
        case (state_reg)
            poh_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = poh_pkg::ST_FOLD;
            end
            poh_pkg::ST_FOLD:
                state_next = poh_pkg::ST_START;
            poh_pkg::ST_START:
            begin
                cordic_start = 1'b1;
                state_next   = poh_pkg::ST_ANGLE;
            end
            poh_pkg::ST_ANGLE:
            begin
                if (cordic_done)
                    state_next = poh_pkg::ST_SCALE;
            end
            poh_pkg::ST_SCALE:
                state_next = poh_pkg::ST_ISSUE;
            poh_pkg::ST_ISSUE:
            begin
                bin_cmd.update = 1'b1;
                state_next     = poh_pkg::ST_COUNT;
            end
            poh_pkg::ST_COUNT:
            begin
                if (bins_done)
                    state_next = poh_pkg::ST_IDLE;
            end
            default:
                state_next = poh_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= poh_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg        <= {head_x[poh_pkg::COORD_W-1], head_x}
                           - {tail_x[poh_pkg::COORD_W-1], tail_x};
            dy_reg        <= {head_y[poh_pkg::COORD_W-1], head_y}
                           - {tail_y[poh_pkg::COORD_W-1], tail_y};
            frame_end_reg <= frame_end;
        end
        if (state_reg == poh_pkg::ST_FOLD)
        begin
            fx_reg <= poh_pkg::fold(dx_reg, box_width_reg);
            fy_reg <= poh_pkg::fold(dy_reg, box_height_reg);
        end
        if (state_reg == poh_pkg::ST_SCALE)
            prod_reg <= PROD_W'(ang) * PROD_W'(nb);
    end

    poh_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (fx_reg),
        .y_in  (fy_reg),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    poh_bins #(
        .MAX_BINS (MAX_BINS)
    ) u_bins (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (bin_cmd),
        .idx        (prod_reg[ANGLE_BITS +: BIN_W]),
        .nb         (nb),
        .done       (bins_done),
        .bin_valid  (bin_valid),
        .bin_number (bin_number),
        .bin_count  (bin_count),
        .last_bin   (last_bin)
    );

    a_cordic_done_in_angle: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == poh_pkg::ST_ANGLE))
        else $error("CORDIC finished outside the angle phase");

    a_accept_starts_fold: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == poh_pkg::ST_FOLD))
        else $error("accepted transaction did not enter fold");

    a_dump_while_counting: assert property (@(posedge clk) disable iff (!rst_n)
        bin_valid |-> ($past(state_reg) == poh_pkg::ST_COUNT))
        else $error("bin strobe outside a frame dump");

endmodule

// ----- hw/rtl/poh_cordic.sv -----
`timescale 1ns / 1ps
// ============================================================================
// poh_cordic
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, atan2 in
// 2^-32 turn units.
// ============================================================================
module poh_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [poh_pkg::FOLD_W-1:0]     x_in,
    input  logic signed [poh_pkg::FOLD_W-1:0]     y_in,
    output logic                                  done,
    output logic [poh_pkg::TURN_W-1:0]            angle
);

    localparam int CW = poh_pkg::CORDIC_W;
    localparam int EXT = poh_pkg::CORDIC_W - poh_pkg::FOLD_W;
    localparam logic [poh_pkg::STEP_W-1:0] LAST_STEP =
        poh_pkg::STEP_W'(CORDIC_STEPS - 1);

    logic signed [CW-1:0]           x_reg, y_reg;
    logic [poh_pkg::TURN_W-1:0]     a_reg;
    logic [poh_pkg::STEP_W-1:0]     step_reg;
    logic                           run_reg, done_reg, zero_reg;

    logic signed [CW-1:0]           xe, ye, xs, ys;
    logic                           y_pos;

    assign xe = {{EXT{x_in[poh_pkg::FOLD_W-1]}}, x_in};
    assign ye = {{EXT{y_in[poh_pkg::FOLD_W-1]}}, y_in};
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign y_pos = !y_reg[CW-1] && (y_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                if (step_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (xe == '0) && (ye == '0);
            // left half plane: rotate by half a turn first
            if (xe[CW-1])
            begin
                x_reg <= -xe;
                y_reg <= -ye;
                a_reg <= poh_pkg::HALF_TURN;
            end
            else
            begin
                x_reg <= xe;
                y_reg <= ye;
                a_reg <= '0;
            end
        end
        else if (run_reg)
        begin
            if (y_pos)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                a_reg <= a_reg + poh_pkg::atan_turn(step_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                a_reg <= a_reg - poh_pkg::atan_turn(step_reg);
            end
        end
    end

    assign done  = done_reg;
    assign angle = zero_reg ? '0 : a_reg;

endmodule

// ----- hw/rtl/poh_bins.sv -----
`timescale 1ns / 1ps
// ============================================================================
// poh_bins
// Bin counter memory: saturating read-modify-write per filament, and the
// frame dump that walks the bins in use and clears them.
// ============================================================================
module poh_bins #(
    parameter int MAX_BINS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  poh_pkg::poh_bin_cmd_t                  cmd,
    input  logic [$clog2(MAX_BINS)-1:0]            idx,
    input  logic [$clog2(MAX_BINS+1)-1:0]          nb,
    output logic                                   done,
    output logic                                   bin_valid,
    output logic [poh_pkg::BIN_NUM_W-1:0]          bin_number,
    output logic [poh_pkg::COUNT_W-1:0]            bin_count,
    output logic                                   last_bin
);

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int NB_W  = $clog2(MAX_BINS + 1);

    poh_pkg::poh_bin_state_t         state_reg, state_next;

    logic [poh_pkg::COUNT_W-1:0]     mem [MAX_BINS];
    logic [poh_pkg::COUNT_W-1:0]     rd_data_reg;
    logic [MAX_BINS-1:0]             valid_reg;
    logic [BIN_W-1:0]                idx_reg, ptr_reg, raddr, last_ptr;
    logic                            dump_reg, done_reg;
    logic                            out_valid_reg, out_last_reg;
    logic [poh_pkg::BIN_NUM_W-1:0]   out_num_reg;
    logic [poh_pkg::COUNT_W-1:0]     out_count_reg;

    logic [poh_pkg::COUNT_W-1:0]     cur, inc;
    logic                            cur_valid, ptr_last, mem_we;

    assign raddr    = (state_reg == poh_pkg::BN_DRD) ? ptr_reg : idx_reg;
    assign last_ptr = BIN_W'(nb - NB_W'(1));
    assign ptr_last = (ptr_reg == last_ptr);
    // an entry without its valid bit reads as zero
    assign cur_valid = (state_reg == poh_pkg::BN_DOUT) ? valid_reg[ptr_reg]
                                                       : valid_reg[idx_reg];
    assign cur = cur_valid ? rd_data_reg : '0;
    assign inc = (cur == poh_pkg::COUNT_MAX) ? cur : cur + 1'b1;
    assign mem_we = (state_reg == poh_pkg::BN_WR);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            poh_pkg::BN_IDLE:
            begin
                if (cmd.update)
                    state_next = poh_pkg::BN_RD;
            end
            poh_pkg::BN_RD:
                state_next = poh_pkg::BN_WR;
            poh_pkg::BN_WR:
                state_next = dump_reg ? poh_pkg::BN_DRD : poh_pkg::BN_IDLE;
            poh_pkg::BN_DRD:
                state_next = poh_pkg::BN_DOUT;
            poh_pkg::BN_DOUT:
                state_next = ptr_last ? poh_pkg::BN_IDLE : poh_pkg::BN_DRD;
            default:
                state_next = poh_pkg::BN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= poh_pkg::BN_IDLE;
            valid_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_num_reg   <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= ((state_reg == poh_pkg::BN_WR) && !dump_reg)
                          || ((state_reg == poh_pkg::BN_DOUT) && ptr_last);
            out_valid_reg <= (state_reg == poh_pkg::BN_DOUT);
            if (state_reg == poh_pkg::BN_WR)
                valid_reg[idx_reg] <= 1'b1;
            if (state_reg == poh_pkg::BN_DOUT)
            begin
                out_num_reg   <= poh_pkg::BIN_NUM_W'(ptr_reg);
                out_count_reg <= cur;
                out_last_reg  <= ptr_last;
                if (ptr_last)
                    valid_reg <= '0;
            end
            else
            begin
                out_last_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == poh_pkg::BN_IDLE) && cmd.update)
        begin
            idx_reg  <= idx;
            dump_reg <= cmd.dump;
        end
        if (state_reg == poh_pkg::BN_WR)
            ptr_reg <= '0;
        else if ((state_reg == poh_pkg::BN_DOUT) && !ptr_last)
            ptr_reg <= ptr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx_reg] <= inc;
        rd_data_reg <= mem[raddr];
    end

    assign done       = done_reg;
    assign bin_valid  = out_valid_reg;
    assign bin_number = out_num_reg;
    assign bin_count  = out_count_reg;
    assign last_bin   = out_last_reg;

    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_bin |-> bin_valid)
        else $error("last_bin without bin_valid");

    a_last_is_top_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (bin_valid && last_bin) |-> (bin_number == poh_pkg::BIN_NUM_W'(last_ptr)))
        else $error("dump ended on the wrong bin");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == poh_pkg::BN_WR) |-> ($past(state_reg) == poh_pkg::BN_RD))
        else $error("counter write without a preceding read");

endmodule
